### design/cpd_pkg.sv
// shared widths, register codes and pipeline constants for the camera projection block
`timescale 1ns / 1ps
package cpd_pkg;

  // port widths
  localparam int PT_W       = 32;
  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register field widths
  localparam int ROW_W = 60;
  localparam int ROT_W = 20;
  localparam int PF_W  = 21;
  localparam int CF_W  = 21;
  localparam int CTR_W = 32;

  // internal datapath widths
  localparam int V_W      = 33;
  localparam int PROD_W   = 53;
  localparam int ACC_W    = 55;
  localparam int D_W      = 36;
  localparam int DMAG_W   = 35;
  localparam int NUM_W    = 60;
  localparam int QUO_BITS = 31;
  localparam int QUO_W    = QUO_BITS + 1;
  localparam int FP16_W   = PF_W + 4;
  localparam int DCQ_W    = CTR_W - 4;
  localparam int MRAW_W   = 34;
  localparam int M_W      = 30;
  localparam int U_W      = 30;
  localparam int SQ_W     = 58;
  localparam int R2_W     = 59;
  localparam int A_W      = 30;
  localparam int AMAG_W   = 27;
  localparam int B_W      = 37;
  localparam int BMAG_W   = 35;
  localparam int POLY_W   = 62;
  localparam int PMAG_W   = 61;
  localparam int FMAG_W   = 50;
  localparam int MF_W     = 52;
  localparam int PW_W     = 40;

  // shifts, limits and rounding constants of the fixed-point chain
  localparam int D_SHIFT    = 18;
  localparam int A_SHIFT    = 52;
  localparam int B_SHIFT    = 52;
  localparam int POLY_SHIFT = 34;
  localparam int FIN_SHIFT  = 40;
  localparam int PIX_SHIFT  = 12;
  localparam int HALF_PIX   = 2048;
  localparam int M_LIMIT    = 1 << 28;
  localparam int PIX_MAX    = 32767;
  localparam int PIX_MIN    = -32768;

  // latencies
  localparam int DIV_LAT  = QUO_BITS + 1;
  localparam int MUL_LAT  = 2;
  localparam int TAIL_LAT = DIV_LAT + 5 + 4 * (MUL_LAT + 1) + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT0,
    REG_ROT1,
    REG_ROT2,
    REG_CENTER_XY,
    REG_CENTER_Z,
    REG_PRINC_FOCAL,
    REG_DIST_CENTER,
    REG_DIST_COEFS
  } cfg_reg_e;

  typedef struct packed {
    logic zero;
    logic valid;
  } tag_t;

endpackage

### design/cpd_intf.sv
// channel interfaces: configuration writes, input points and output pixels
`timescale 1ns / 1ps
interface cpd_cfg_if;
  import cpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface cpd_point_if;
  import cpd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;
  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface cpd_pixel_if;
  import cpd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    in_image;
  modport source (output valid, output pixel_x, output pixel_y, output in_image, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input in_image, output ready);
endinterface

### design/cpd_delay.sv
// enabled shift line that keeps side data in step with the pipeline
`timescale 1ns / 1ps
module cpd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) taps[i] <= '0;
    end else if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[DEPTH-1];
endmodule

### design/cpd_mulsh.sv
// two-stage signed multiply with truncation toward zero, as magnitude and sign
`timescale 1ns / 1ps
module cpd_mulsh #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SH = 32,
  parameter int MW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic [MW-1:0]        mag,
  output logic                 neg
);
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AW-1:0]      ma;
  logic [BW-1:0]      mb;
  logic [AL+BL-1:0]   p_ll;
  logic [AL+BH-1:0]   p_lh;
  logic [AH+BL-1:0]   p_hl;
  logic [AH+BH-1:0]   p_hh;
  logic               s_neg;
  logic [PW-1:0]      sum;

  assign ma = a[AW-1] ? $unsigned(-a) : $unsigned(a);
  assign mb = b[BW-1] ? $unsigned(-b) : $unsigned(b);

  // split into four partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p_ll  <= ma[AL-1:0] * mb[BL-1:0];
      p_lh  <= ma[AL-1:0] * mb[BW-1:BL];
      p_hl  <= ma[AW-1:AL] * mb[BL-1:0];
      p_hh  <= ma[AW-1:AL] * mb[BW-1:BL];
      s_neg <= a[AW-1] ^ b[BW-1];
    end
  end

  assign sum = PW'(p_ll) + (PW'(p_lh) << BL) + (PW'(p_hl) << AL) + (PW'(p_hh) << (AL + BL));

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= MW'(sum >> SH);
      neg <= s_neg;
    end
  end
endmodule

### design/cpd_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
`timescale 1ns / 1ps
module cpd_div #(
  parameter int NW = 60,
  parameter int DW = 35,
  parameter int QB = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB:0]   quo
);
  localparam int W = (DW + QB + 1 > NW) ? DW + QB + 1 : NW;

  logic [NW-1:0] rem [QB+1];
  logic [DW-1:0] dv  [QB+1];
  logic [QB-1:0] qt  [QB+1];
  logic          ovf [QB+1];

  // quotient too large for the bit stages: flag it and saturate at the end
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      qt[0]  <= '0;
      ovf[0] <= W'(num) >= (W'(den) << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int SB = QB - k;
    logic [W-1:0] rw;
    logic [W-1:0] dsh;
    logic         ge;

    assign rw  = W'(rem[k-1]);
    assign dsh = W'(dv[k-1]) << SB;
    assign ge  = rw >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]     <= ge ? NW'(rw - dsh) : rem[k-1];
        dv[k]      <= dv[k-1];
        qt[k]      <= qt[k-1] | (QB'(ge) << SB);
        ovf[k]     <= ovf[k-1];
      end
    end
  end

  assign quo = ovf[QB] ? ((QB+1)'(1) << QB) : {1'b0, qt[QB]};
endmodule

### design/camera_projection_radial_distortion.sv
// top level: pinhole projection with radial distortion, one point per cycle unless pixel stalls
//
//   channel  dir  handshake      word
//   cfg      in   valid/ready    index, data (ready tied high)
//   point    in   valid/ready    point_x, point_y, point_z
//   pixel    out  valid/ready    pixel_x, pixel_y, in_image
//
// one point per cycle sustained while pixel is not stalled
// the depth is set mostly by the 32-stage divider and four two-stage multipliers
// rst clears the configuration registers and the valid bits; no clearing pass
// a stall on pixel freezes the whole pipeline and point.ready drops at once
`timescale 1ns / 1ps
module camera_projection_radial_distortion #(
  parameter int IMAGE_WIDTH  = 4096,
  parameter int IMAGE_HEIGHT = 4096
) (
  input  logic         clk,
  input  logic         rst,
  cpd_cfg_if.sink      cfg,
  cpd_point_if.sink    point,
  cpd_pixel_if.source  pixel
);
  import cpd_pkg::*;

  // configuration registers
  logic [ROW_W-1:0]        rotation_row0;
  logic [ROW_W-1:0]        rotation_row1;
  logic [ROW_W-1:0]        rotation_row2;
  logic [2*CTR_W-1:0]      center_xy;
  logic [CTR_W-1:0]        center_z;
  logic [3*PF_W-1:0]       principal_and_focal;
  logic [2*CTR_W-1:0]      distortion_center;
  logic [3*CF_W-1:0]       distortion_coefs;

  // decoded fields
  logic signed [ROT_W-1:0] rot [3][3];
  logic signed [CTR_W-1:0] ctr [3];
  logic signed [PF_W-1:0]  focal;
  logic signed [FP16_W-1:0] f16 [2];
  logic signed [CF_W-1:0]  k0, k1, k2;
  logic signed [CTR_W-1:0] dcb [2];
  logic signed [DCQ_W-1:0] dcq [2];

  logic adv;

  // stages
  logic                     s1_valid, s2_valid, s3_valid;
  logic signed [V_W-1:0]    v [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [ACC_W-1:0]  accb [3];
  logic signed [D_W-1:0]    d [3];
  logic [PF_W-1:0]          fmag;
  logic [D_W-1:0]           dabs [3];
  logic [NUM_W-1:0]         nmag [2];
  logic [DMAG_W-1:0]        dmag_z;
  logic [1:0]               qneg;
  tag_t                     tag4;
  logic [QUO_W-1:0]         quo [2];
  logic [1:0]               qneg_d;
  logic signed [MRAW_W-1:0] mraw [2];
  logic signed [M_W-1:0]    m6 [2];
  logic signed [M_W-1:0]    m7 [2];
  logic signed [U_W-1:0]    u7 [2];
  logic signed [M_W-1:0]    m8 [2];
  logic signed [U_W-1:0]    u8 [2];
  logic [SQ_W-1:0]          sq [2];
  logic signed [M_W-1:0]    m9 [2];
  logic signed [U_W-1:0]    u9 [2];
  logic [R2_W-1:0]          r2;
  logic [R2_W-1:0]          r2_d3;
  logic [R2_W-1:0]          r2_d6;
  logic [AMAG_W-1:0]        amag;
  logic                     aneg;
  logic signed [A_W-1:0]    acoef;
  logic [BMAG_W-1:0]        bmag;
  logic                     bneg;
  logic signed [B_W-1:0]    bcoef;
  logic [PMAG_W-1:0]        pmag;
  logic                     pneg;
  logic signed [POLY_W-1:0] poly;
  logic [2*U_W-1:0]         u_d9;
  logic [2*M_W-1:0]         m_d11;
  logic signed [U_W-1:0]    uf [2];
  logic signed [M_W-1:0]    mf_base [2];
  logic [FMAG_W-1:0]        fin_mag [2];
  logic                     fin_neg [2];
  logic signed [MF_W-1:0]   mf [2];
  logic signed [MF_W-1:0]   t [2];
  logic signed [MF_W-1:0]   tb [2];
  logic signed [PW_W-1:0]   pw [2];
  tag_t                     tag_p2;
  logic signed [PIX_W-1:0]  clp [2];
  logic                     in_bounds;

  // configuration port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_row0       <= '0;
      rotation_row1       <= '0;
      rotation_row2       <= '0;
      center_xy           <= '0;
      center_z            <= '0;
      principal_and_focal <= '0;
      distortion_center   <= '0;
      distortion_coefs    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_ROT0:        rotation_row0       <= cfg.data[ROW_W-1:0];
        REG_ROT1:        rotation_row1       <= cfg.data[ROW_W-1:0];
        REG_ROT2:        rotation_row2       <= cfg.data[ROW_W-1:0];
        REG_CENTER_XY:   center_xy           <= cfg.data[2*CTR_W-1:0];
        REG_CENTER_Z:    center_z            <= cfg.data[CTR_W-1:0];
        REG_PRINC_FOCAL: principal_and_focal <= cfg.data[3*PF_W-1:0];
        REG_DIST_CENTER: distortion_center   <= cfg.data[2*CTR_W-1:0];
        REG_DIST_COEFS:  distortion_coefs    <= cfg.data[3*CF_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rot[0][j] = rotation_row0[ROT_W*j +: ROT_W];
      rot[1][j] = rotation_row1[ROT_W*j +: ROT_W];
      rot[2][j] = rotation_row2[ROT_W*j +: ROT_W];
    end
    ctr[0] = center_xy[CTR_W-1:0];
    ctr[1] = center_xy[2*CTR_W-1:CTR_W];
    ctr[2] = center_z;
    focal  = principal_and_focal[3*PF_W-1:2*PF_W];
    for (int i = 0; i < 2; i++) begin
      f16[i] = {principal_and_focal[PF_W*i +: PF_W], 4'b0000};
      // distortion centre to Q.12, truncated toward zero
      dcb[i] = $signed(distortion_center[CTR_W*i +: CTR_W])
             + (distortion_center[CTR_W*i + CTR_W - 1] ? CTR_W'(15) : CTR_W'(0));
      dcq[i] = dcb[i][CTR_W-1:4];
    end
    k0 = distortion_coefs[CF_W-1:0];
    k1 = distortion_coefs[2*CF_W-1:CF_W];
    k2 = distortion_coefs[3*CF_W-1:2*CF_W];
  end

  // whole pipeline advances unless the output word is stuck
  assign adv         = !pixel.valid || pixel.ready;
  assign point.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      tag4     <= '0;
    end else if (adv) begin
      s1_valid <= point.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      tag4     <= '{zero: d[2] == '0, valid: s3_valid};
    end
  end

  // P - S
  always_ff @(posedge clk) begin
    if (adv) begin
      v[0] <= V_W'(point.point_x) - V_W'(ctr[0]);
      v[1] <= V_W'(point.point_y) - V_W'(ctr[1]);
      v[2] <= V_W'(point.point_z) - V_W'(ctr[2]);
    end
  end

  // rotation products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PROD_W'(rot[i][j]) * PROD_W'(v[j]);
        end
      end
    end
  end

  // row sums, Q.34 to Q.16 toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = ACC_W'(prod[i][0]) + ACC_W'(prod[i][1]) + ACC_W'(prod[i][2]);
      accb[i] = acc[i] + (acc[i][ACC_W-1] ? ACC_W'((1 << D_SHIFT) - 1) : ACC_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) d[i] <= D_W'(accb[i] >>> D_SHIFT);
    end
  end

  // divider operands as magnitudes
  always_comb begin
    fmag = focal[PF_W-1] ? $unsigned(-focal) : $unsigned(focal);
    for (int i = 0; i < 3; i++) dabs[i] = d[i][D_W-1] ? $unsigned(-d[i]) : $unsigned(d[i]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        nmag[i] <= (NUM_W'(fmag) * NUM_W'(dabs[i][DMAG_W-1:0])) << 4;
        qneg[i] <= focal[PF_W-1] ^ d[i][D_W-1] ^ d[2][D_W-1];
      end
      dmag_z <= dabs[2][DMAG_W-1:0];
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_div
    cpd_div #(
      .NW (NUM_W),
      .DW (DMAG_W),
      .QB (QUO_BITS)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (nmag[i]),
      .den (dmag_z),
      .quo (quo[i])
    );
  end

  cpd_delay #(.WIDTH(2), .DEPTH(DIV_LAT)) u_qneg_dly (
    .clk (clk), .rst (rst), .en (adv), .d (qneg), .q (qneg_d)
  );

  cpd_delay #(.WIDTH($bits(tag_t)), .DEPTH(TAIL_LAT)) u_tag_dly (
    .clk (clk), .rst (rst), .en (adv), .d (tag4), .q (tag_p2)
  );

  // m = 16F - q, clamp, then offset from the distortion centre
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        mraw[i] <= qneg_d[i] ? MRAW_W'(f16[i]) + MRAW_W'(quo[i])
                             : MRAW_W'(f16[i]) - MRAW_W'(quo[i]);
        if (mraw[i] > MRAW_W'(M_LIMIT)) begin
          m6[i] <= M_W'(M_LIMIT);
        end else if (mraw[i] < MRAW_W'(-M_LIMIT)) begin
          m6[i] <= M_W'(-M_LIMIT);
        end else begin
          m6[i] <= M_W'(mraw[i]);
        end
        m7[i] <= m6[i];
        u7[i] <= U_W'(m6[i]) - U_W'(dcq[i]);
        m8[i] <= m7[i];
        u8[i] <= u7[i];
        sq[i] <= SQ_W'((2*U_W)'(u7[i]) * (2*U_W)'(u7[i]));
        m9[i] <= m8[i];
        u9[i] <= u8[i];
      end
      r2 <= R2_W'(sq[0]) + R2_W'(sq[1]);
    end
  end

  // Horner chain for the radial polynomial
  cpd_mulsh #(.AW(CF_W), .BW(R2_W+1), .SH(A_SHIFT), .MW(AMAG_W)) u_mul_a (
    .clk (clk), .en (adv), .a (k2), .b ($signed({1'b0, r2})), .mag (amag), .neg (aneg)
  );

  cpd_delay #(.WIDTH(R2_W), .DEPTH(MUL_LAT+1)) u_r2_dly_a (
    .clk (clk), .rst (rst), .en (adv), .d (r2), .q (r2_d3)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      acoef <= aneg ? A_W'(k1) - A_W'(amag) : A_W'(k1) + A_W'(amag);
    end
  end

  cpd_mulsh #(.AW(A_W), .BW(R2_W+1), .SH(B_SHIFT), .MW(BMAG_W)) u_mul_b (
    .clk (clk), .en (adv), .a (acoef), .b ($signed({1'b0, r2_d3})), .mag (bmag), .neg (bneg)
  );

  cpd_delay #(.WIDTH(R2_W), .DEPTH(MUL_LAT+1)) u_r2_dly_b (
    .clk (clk), .rst (rst), .en (adv), .d (r2_d3), .q (r2_d6)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      bcoef <= bneg ? B_W'(k0) - B_W'(bmag) : B_W'(k0) + B_W'(bmag);
    end
  end

  cpd_mulsh #(.AW(B_W), .BW(R2_W+1), .SH(POLY_SHIFT), .MW(PMAG_W)) u_mul_p (
    .clk (clk), .en (adv), .a (bcoef), .b ($signed({1'b0, r2_d6})), .mag (pmag), .neg (pneg)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      poly <= pneg ? -POLY_W'(pmag) : POLY_W'(pmag);
    end
  end

  cpd_delay #(.WIDTH(2*U_W), .DEPTH(3*(MUL_LAT+1))) u_u_dly (
    .clk (clk), .rst (rst), .en (adv), .d ({u9[1], u9[0]}), .q (u_d9)
  );

  cpd_delay #(.WIDTH(2*M_W), .DEPTH(4*(MUL_LAT+1)-1)) u_m_dly (
    .clk (clk), .rst (rst), .en (adv), .d ({m9[1], m9[0]}), .q (m_d11)
  );

  assign uf[0]      = u_d9[U_W-1:0];
  assign uf[1]      = u_d9[2*U_W-1:U_W];
  assign mf_base[0] = m_d11[M_W-1:0];
  assign mf_base[1] = m_d11[2*M_W-1:M_W];

  for (genvar i = 0; i < 2; i++) begin : g_fin
    cpd_mulsh #(.AW(POLY_W), .BW(U_W), .SH(FIN_SHIFT), .MW(FMAG_W)) u_mul_f (
      .clk (clk), .en (adv), .a (poly), .b (uf[i]), .mag (fin_mag[i]), .neg (fin_neg[i])
    );
  end

  // rounding: add one half, truncate toward zero
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      tb[i] = t[i] + (t[i][MF_W-1] ? MF_W'((1 << PIX_SHIFT) - 1) : MF_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        mf[i] <= fin_neg[i] ? MF_W'(mf_base[i]) - MF_W'(fin_mag[i])
                            : MF_W'(mf_base[i]) + MF_W'(fin_mag[i]);
        t[i]  <= mf[i] + MF_W'(HALF_PIX);
        pw[i] <= PW_W'(tb[i] >>> PIX_SHIFT);
      end
    end
  end

  // saturate and test the image bounds
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (pw[i] > PW_W'(PIX_MAX)) begin
        clp[i] = PIX_W'(PIX_MAX);
      end else if (pw[i] < PW_W'(PIX_MIN)) begin
        clp[i] = PIX_W'(PIX_MIN);
      end else begin
        clp[i] = pw[i][PIX_W-1:0];
      end
    end
    in_bounds = !clp[0][PIX_W-1] && (int'(clp[0]) < IMAGE_WIDTH)
             && !clp[1][PIX_W-1] && (int'(clp[1]) < IMAGE_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (adv) begin
      pixel.valid <= tag_p2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tag_p2.zero) begin
        pixel.pixel_x  <= '0;
        pixel.pixel_y  <= '0;
        pixel.in_image <= 1'b0;
      end else begin
        pixel.pixel_x  <= clp[0];
        pixel.pixel_y  <= clp[1];
        pixel.in_image <= in_bounds;
      end
    end
  end
endmodule

### design/cpd_checker.sv
// port-level checks for the camera projection block, bound to the top level
`timescale 1ns / 1ps
module cpd_checker #(
  parameter int IMAGE_WIDTH  = 4096,
  parameter int IMAGE_HEIGHT = 4096
) (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] pixel_x,
  input logic signed [15:0] pixel_y,
  input logic               in_image
);

  // a waiting result word is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // input only backs up when the output is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without output stall");

  // a set in_image flag implies coordinates inside the image
  a_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_image |-> pixel_x >= 0 && pixel_y >= 0
      && int'(pixel_x) < IMAGE_WIDTH && int'(pixel_y) < IMAGE_HEIGHT)
    else $error("in_image set for pixel outside image");

endmodule

bind camera_projection_radial_distortion cpd_checker #(
  .IMAGE_WIDTH  (IMAGE_WIDTH),
  .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_cpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (point.ready),
  .out_valid (pixel.valid),
  .out_ready (pixel.ready),
  .pixel_x   (pixel.pixel_x),
  .pixel_y   (pixel.pixel_y),
  .in_image  (pixel.in_image)
);
